/* sv/tblmc_pkg.sv */
// shared types, codes and constants of the two-button led mode controller
package tblmc_pkg;

  // field widths
  localparam int TIME_W  = 32;
  localparam int MODE_W  = 3;
  localparam int SPEED_W = 4;
  localparam int IVL_W   = 16;

  // depth of every queue, between the parts and at the result side
  localparam int QDEPTH = 2;

  // defaults of the top level parameters
  localparam int BLINK_BASE_MS_DEF = 2000;
  localparam int SPEED_MAX_DEF     = 10;

  // led modes
  localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BOTH  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_L1    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_L2    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ALT   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_BLINK = 3'd5;

  // leading button
  localparam logic [1:0] LEAD_NONE = 2'd0;
  localparam logic [1:0] LEAD_B1   = 2'd1;
  localparam logic [1:0] LEAD_B2   = 2'd2;

  // led level pairs, bit 0 is led one
  localparam logic [1:0] LEDS_NONE = 2'b00;
  localparam logic [1:0] LEDS_ONE  = 2'b01;
  localparam logic [1:0] LEDS_TWO  = 2'b10;
  localparam logic [1:0] LEDS_BOTH = 2'b11;

  // button events found by the front part
  typedef enum logic [1:0] {
    EV_NONE,
    EV_COMBO,
    EV_REL1,
    EV_REL2
  } evt_t;

  // classified request handed from front to back
  typedef struct packed {
    evt_t              evt;
    logic [TIME_W-1:0] now_ms;
  } mid_item_t;

  // result request
  typedef struct packed {
    logic               led1_on;
    logic               led2_on;
    logic [MODE_W-1:0]  led_mode;
    logic [SPEED_W-1:0] blink_speed;
  } res_item_t;

  localparam int MID_W = $bits(mid_item_t);
  localparam int RES_W = $bits(res_item_t);

endpackage

/* sv/tblmc_fifo.sv */
// small register queue used between the parts and at the result side
module tblmc_fifo #(
  parameter int WIDTH = tblmc_pkg::MID_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);
  import tblmc_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [WIDTH-1:0] mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* sv/tblmc_front.sv */
// front part: button tracking and event classification
module tblmc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic                       btn1_down,
  input  logic                       btn2_down,
  input  logic [tblmc_pkg::TIME_W-1:0] now_ms,
  output tblmc_pkg::mid_item_t       item
);
  import tblmc_pkg::*;

  logic lvl1_r, lvl2_r;
  logic hnd1_r, hnd1_nxt, hnd2_r, hnd2_nxt;
  logic skp1_r, skp1_nxt, skp2_r, skp2_nxt;
  logic arm1, arm2;
  evt_t evt;

  // a level change re-arms the button
  assign arm1 = (lvl1_r != btn1_down) || !hnd1_r;
  assign arm2 = (lvl2_r != btn2_down) || !hnd2_r;

  // combo has priority, then release of button one, then button two
  always_comb begin
    hnd1_nxt = !arm1;
    hnd2_nxt = !arm2;
    skp1_nxt = skp1_r;
    skp2_nxt = skp2_r;
    evt      = EV_NONE;
    if (btn1_down && btn2_down && arm1 && arm2) begin
      hnd1_nxt = 1'b1;
      hnd2_nxt = 1'b1;
      skp1_nxt = 1'b1;
      skp2_nxt = 1'b1;
      evt      = EV_COMBO;
    end else if (!btn1_down && arm1) begin
      evt      = skp1_r ? EV_NONE : EV_REL1;
      skp1_nxt = 1'b0;
      hnd1_nxt = 1'b1;
    end else if (!btn2_down && arm2) begin
      evt      = skp2_r ? EV_NONE : EV_REL2;
      skp2_nxt = 1'b0;
      hnd2_nxt = 1'b1;
    end
  end

  assign item.evt    = evt;
  assign item.now_ms = now_ms;

  // button state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl1_r <= 1'b0;
      lvl2_r <= 1'b0;
      hnd1_r <= 1'b0;
      hnd2_r <= 1'b0;
      skp1_r <= 1'b0;
      skp2_r <= 1'b0;
    end else if (accept) begin
      lvl1_r <= btn1_down;
      lvl2_r <= btn2_down;
      hnd1_r <= hnd1_nxt;
      hnd2_r <= hnd2_nxt;
      skp1_r <= skp1_nxt;
      skp2_r <= skp2_nxt;
    end
  end

endmodule

/* sv/tblmc_back.sv */
// back part: mode machine, speed counter and led drive
module tblmc_back #(
  parameter int BLINK_BASE_MS = tblmc_pkg::BLINK_BASE_MS_DEF,
  parameter int SPEED_MAX     = tblmc_pkg::SPEED_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tblmc_pkg::mid_item_t item,
  input  logic                 item_empty,
  output logic                 item_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output tblmc_pkg::res_item_t res
);
  import tblmc_pkg::*;

  localparam int NSPD = 1 << SPEED_W;

  logic [MODE_W-1:0]  mode_r, mode_nxt, mine;
  logic [SPEED_W-1:0] speed_r, speed_nxt, speed_inc;
  logic [1:0]         lead_r, lead_nxt, who;
  logic [TIME_W-1:0]  last_r, last_nxt, elapsed;
  logic               phase_r, phase_nxt;
  logic [1:0]         leds_r, leds_nxt;
  logic               is_rel, expire, go;
  logic [IVL_W-1:0]   ivl_alt [NSPD];
  logic [IVL_W-1:0]   ivl_blk [NSPD];
  logic [IVL_W-1:0]   ivl;

  // interval tables indexed by the raw speed, clamp folded in
  for (genvar g = 0; g < NSPD; g++) begin : g_ivl
    localparam int S  = (g < 1) ? 1 : ((g > SPEED_MAX) ? SPEED_MAX : g);
    localparam int IA = BLINK_BASE_MS / (2 * S);
    localparam int IB = BLINK_BASE_MS / (5 * S);
    assign ivl_alt[g] = IVL_W'(IA);
    assign ivl_blk[g] = IVL_W'(IB);
  end

  assign go       = !item_empty && !res_full;
  assign item_pop = go;
  assign res_push = go;

  assign speed_inc = (speed_r < SPEED_W'(SPEED_MAX)) ? speed_r + 1'b1 : speed_r;

  // event handling
  always_comb begin
    mode_nxt  = mode_r;
    speed_nxt = speed_r;
    lead_nxt  = lead_r;
    is_rel    = 1'b0;
    who       = LEAD_B1;
    mine      = MODE_L1;
    case (item.evt)
      EV_COMBO: begin
        if (mode_r == MODE_BLINK) begin
          speed_nxt = speed_inc;
        end else begin
          speed_nxt = '0;
          mode_nxt  = MODE_BLINK;
        end
      end
      EV_REL1: begin
        is_rel = 1'b1;
      end
      EV_REL2: begin
        is_rel = 1'b1;
        who    = LEAD_B2;
        mine   = MODE_L2;
      end
      default: ;
    endcase
    if (is_rel) begin
      if (lead_r != who) begin
        lead_nxt = who;
        mode_nxt = MODE_OFF;
      end else begin
        case (mode_r)
          MODE_OFF, MODE_BLINK: mode_nxt = mine;
          MODE_L1, MODE_L2:     mode_nxt = (mode_r == mine) ? MODE_BOTH : mine;
          MODE_ALT:             speed_nxt = speed_inc;
          MODE_BOTH: begin
            speed_nxt = '0;
            mode_nxt  = MODE_ALT;
          end
          default: ;
        endcase
      end
    end
  end

  // led drive with blink timer on the updated mode and speed
  assign ivl     = (mode_nxt == MODE_BLINK) ? ivl_blk[speed_nxt] : ivl_alt[speed_nxt];
  assign elapsed = item.now_ms - last_r;
  assign expire  = elapsed > {{(TIME_W - IVL_W){1'b0}}, ivl};

  always_comb begin
    leds_nxt  = leds_r;
    phase_nxt = phase_r;
    last_nxt  = last_r;
    case (mode_nxt)
      MODE_OFF:  leds_nxt = LEDS_NONE;
      MODE_BOTH: leds_nxt = LEDS_BOTH;
      MODE_L1:   leds_nxt = LEDS_ONE;
      MODE_L2:   leds_nxt = LEDS_TWO;
      MODE_ALT, MODE_BLINK: begin
        if (expire) begin
          if (mode_nxt == MODE_BLINK) begin
            leds_nxt = phase_r ? LEDS_NONE : LEDS_BOTH;
          end else begin
            leds_nxt = phase_r ? LEDS_TWO : LEDS_ONE;
          end
          phase_nxt = !phase_r;
          last_nxt  = item.now_ms;
        end
      end
      default: ;
    endcase
  end

  assign res.led1_on     = leds_nxt[0];
  assign res.led2_on     = leds_nxt[1];
  assign res.led_mode    = mode_nxt;
  assign res.blink_speed = speed_nxt;

  // mode and timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_OFF;
      speed_r <= SPEED_W'(1);
      lead_r  <= LEAD_NONE;
      last_r  <= '0;
      phase_r <= 1'b0;
      leds_r  <= LEDS_NONE;
    end else if (go) begin
      mode_r  <= mode_nxt;
      speed_r <= speed_nxt;
      lead_r  <= lead_nxt;
      last_r  <= last_nxt;
      phase_r <= phase_nxt;
      leds_r  <= leds_nxt;
    end
  end

endmodule

/* sv/two_button_led_mode_controller.sv */
// top level of the two-button led mode controller
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+-------------------------------------------
//  in_      | request   | push / full      | in_btn1_down, in_btn2_down, in_now_ms
//  out_     | result    | empty / pop      | out_led1_on, out_led2_on, out_led_mode,
//           |           |                  | out_blink_speed
//
// One poll tick per cycle is accepted while full is low; each gives exactly one result.
// A result reaches the out_ ports through both queues: the front classifies its
// request into the event queue at the accepting edge, and the mode machine moves
// it on into the result queue at a later edge, once the result queue has room.
// Reset is one cycle of rst_n low; no clearing pass follows.
// When pop stays low the result queue fills, then the event queue, then full rises.
module two_button_led_mode_controller #(
  parameter int BLINK_BASE_MS = tblmc_pkg::BLINK_BASE_MS_DEF,
  parameter int SPEED_MAX     = tblmc_pkg::SPEED_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_btn1_down,
  input  logic                          in_btn2_down,
  input  logic [tblmc_pkg::TIME_W-1:0]  in_now_ms,
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_led1_on,
  output logic                          out_led2_on,
  output logic [tblmc_pkg::MODE_W-1:0]  out_led_mode,
  output logic [tblmc_pkg::SPEED_W-1:0] out_blink_speed
);
  import tblmc_pkg::*;

  mid_item_t        front_item, back_item;
  res_item_t        back_res, out_res;
  logic [MID_W-1:0] mid_rdata;
  logic [RES_W-1:0] res_rdata;
  logic             accept, mid_empty, mid_pop, res_full, res_push;

  assign accept = push && !full;

  // front classifier
  tblmc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .btn1_down (in_btn1_down),
    .btn2_down (in_btn2_down),
    .now_ms    (in_now_ms),
    .item      (front_item)
  );

  // event queue between front and back
  tblmc_fifo #(
    .WIDTH (MID_W)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata (front_item),
    .full  (full),
    .pop   (mid_pop),
    .empty (mid_empty),
    .rdata (mid_rdata)
  );

  assign back_item = mid_item_t'(mid_rdata);

  // mode machine and led drive
  tblmc_back #(
    .BLINK_BASE_MS (BLINK_BASE_MS),
    .SPEED_MAX     (SPEED_MAX)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (back_item),
    .item_empty (mid_empty),
    .item_pop   (mid_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (back_res)
  );

  // result queue
  tblmc_fifo #(
    .WIDTH (RES_W)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .empty (empty),
    .rdata (res_rdata)
  );

  assign out_res         = res_item_t'(res_rdata);
  assign out_led1_on     = out_res.led1_on;
  assign out_led2_on     = out_res.led2_on;
  assign out_led_mode    = out_res.led_mode;
  assign out_blink_speed = out_res.blink_speed;

  // speed never passes its ceiling
  a_speed_max: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_blink_speed <= SPEED_W'(SPEED_MAX))
    else $error("blink speed above ceiling");

  // only the six defined modes come out
  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_led_mode <= MODE_BLINK)
    else $error("undefined led mode");

  // the both-on and off modes drive their fixed led pattern
  a_both_on: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_led_mode == MODE_BOTH) |-> (out_led1_on && out_led2_on))
    else $error("both-on mode with an led dark");

  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_led_mode == MODE_OFF) |-> (!out_led1_on && !out_led2_on))
    else $error("off mode with an led lit");

  // an accepted request into an empty event queue, with room in the result queue, reaches the back part next cycle
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mid_empty && !res_full) |=> !mid_empty)
    else $error("accepted request lost before the back part");

endmodule
